// ----- design/mi4_pkg.sv -----
// Shared types and constants for the 4x4 matrix inverse block.
`default_nettype none
package mi4_pkg;
    localparam int ELEMS     = 16;
    localparam int WIDE_W    = 192;   // exact accumulator width
    localparam int QUOT_BITS = 192;   // restoring-division steps

    typedef logic signed [31:0]       t_elem;
    typedef logic signed [WIDE_W-1:0] t_wide;

    // Row or column of a minor: the k-th index of 0..3 that skips 'skip'.
    function automatic logic [1:0] minor_idx(input logic [1:0] skip, input logic [1:0] k);
        logic [1:0] r;
        r = (k >= skip) ? k + 2'd1 : k;
        return r;
    endfunction
endpackage
`default_nettype wire

// ----- design/mi4_div.sv -----
// Iterative restoring divider: trunc(num / den), one quotient bit per cycle.
`default_nettype none
module mi4_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_go,
    input  wire mi4_pkg::t_wide     i_num,   // magnitude
    input  wire mi4_pkg::t_wide     i_den,   // magnitude, nonzero
    output logic                    o_done,
    output logic [31:0]             o_quot   // saturated to 32 bits unsigned
);
    import mi4_pkg::*;

    logic [WIDE_W-1:0] r_num, r_den, r_rem, r_q;
    logic [7:0]        r_cnt;
    logic              r_busy;
    logic [WIDE_W:0]   rem_sh, diff;

    assign rem_sh = {r_rem, r_num[WIDE_W-1]};
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= 8'(QUOT_BITS - 1);
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_q    <= '0;
            end else if (r_busy) begin
                r_num <= r_num << 1;
                if (!diff[WIDE_W]) begin
                    r_rem <= diff[WIDE_W-1:0];
                    r_q   <= {r_q[WIDE_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[WIDE_W-1:0];
                    r_q   <= {r_q[WIDE_W-2:0], 1'b0};
                end
                if (r_cnt == 8'd0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
                r_cnt <= r_cnt - 8'd1;
            end
        end
    end

    assign o_quot = (|r_q[WIDE_W-1:32]) ? 32'hFFFF_FFFF : r_q[31:0];
endmodule
`default_nettype wire

// ----- design/matrix_inverse_4x4.sv -----
// Top level of the streamed 4x4 matrix inverse (adjugate over determinant).
`default_nettype none
// Usage: raise start with one Q16.16 element per request, array order
// 0..15, while busy is low. A request is taken at each edge where start is
// high and busy is low, so loading can run at one element per cycle. After
// the sixteenth element the block goes busy. One shared 33x33 signed
// multiplier builds each of the 16 cofactors as six triple products. Each
// triple product is built from the pair product, then the low and the high
// half of the pair times the third factor. The determinant along the first
// row follows, one step for each 32-bit slice of four cofactors. Each result
// then passes through S_DIVGO, which starts the shared 192-step restoring
// divider, and S_DIVW, which waits for it and registers the result. A
// singular matrix skips the division wait. Each result appears on o_out_*
// for one cycle marked by o_out_valid; the receiver cannot stall. A zero
// determinant gives sixteen results of value 0 with o_singular set.
module matrix_inverse_4x4 (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire logic [31:0]    i_elem_value,
    output logic                o_out_valid,
    output logic [3:0]          o_out_index,
    output logic [31:0]         o_out_value,
    output logic                o_singular,
    output logic                o_last
);
    import mi4_pkg::*;

    typedef enum logic [2:0] {S_LOAD, S_COF, S_DET, S_DIVGO, S_DIVW} t_state;

    t_state             r_state;
    logic [31:0]        r_mat [ELEMS];   // element store, written in load order
    t_wide              r_adj [ELEMS];   // adjugate entries
    logic [3:0]         r_cnt;           // load count / det slice / result index
    logic [3:0]         r_idx;           // cofactor being built (adjugate index)
    logic [2:0]         r_term;          // triple product within cofactor
    logic [1:0]         r_ph;            // 0: x*y, 1: low half *z, 2: high half *z
    logic signed [63:0] r_prod;          // pair product x*y
    t_wide              r_acc, r_det;
    logic               r_sing, r_neg;

    // Shared multiplier. Wide values go through it in 32-bit slices: the
    // lower slices zero-extended, the top slice sign-extended.
    logic signed [32:0] mul_a, mul_b, z_op;
    logic signed [65:0] mul_p;
    assign mul_p = mul_a * mul_b;

    // Minor selection for the current cofactor: adjugate (r,c) uses cof(c,r).
    logic [1:0] crow, ccol, a0, a1, b0, b1, b2, ci, cj, ck, sj;
    logic       tneg, sneg;
    t_wide      det_src;
    always_comb begin
        crow = r_idx[1:0];
        ccol = r_idx[3:2];
        // permutation of columns for term
        ci = 2'd0; cj = 2'd1; ck = 2'd2; tneg = 1'b0;
        unique case (r_term)
            3'd0: begin ci = 2'd0; cj = 2'd1; ck = 2'd2; tneg = 1'b0; end
            3'd1: begin ci = 2'd0; cj = 2'd2; ck = 2'd1; tneg = 1'b1; end
            3'd2: begin ci = 2'd1; cj = 2'd0; ck = 2'd2; tneg = 1'b1; end
            3'd3: begin ci = 2'd1; cj = 2'd2; ck = 2'd0; tneg = 1'b0; end
            3'd4: begin ci = 2'd2; cj = 2'd0; ck = 2'd1; tneg = 1'b0; end
            3'd5: begin ci = 2'd2; cj = 2'd1; ck = 2'd0; tneg = 1'b1; end
            default: begin ci = 2'd0; cj = 2'd1; ck = 2'd2; tneg = 1'b0; end
        endcase
        a0 = minor_idx(crow, 2'd0);
        a1 = minor_idx(crow, 2'd1);
        b0 = minor_idx(ccol, ci);
        b1 = minor_idx(ccol, cj);
        b2 = minor_idx(ccol, ck);
        sj = minor_idx(crow, 2'd2);
        // term sign and checkerboard sign both go onto the third factor
        sneg = tneg ^ crow[0] ^ ccol[0];
        z_op = 33'(signed'(r_mat[{sj, b2}]));
        if (sneg) z_op = -z_op;
        det_src = r_adj[{r_cnt[3:2], 2'b00}];
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_COF) begin
            case (r_ph)
                2'd0: begin
                    mul_a = 33'(signed'(r_mat[{a0, b0}]));
                    mul_b = 33'(signed'(r_mat[{a1, b1}]));
                end
                2'd1: begin
                    mul_a = signed'({1'b0, r_prod[31:0]});
                    mul_b = z_op;
                end
                default: begin
                    mul_a = 33'(signed'(r_prod[63:32]));
                    mul_b = z_op;
                end
            endcase
        end else if (r_state == S_DET) begin
            // cofactors fit in 97 signed bits: three plain slices and a top one
            case (r_cnt[1:0])
                2'd0:    mul_a = signed'({1'b0, det_src[31:0]});
                2'd1:    mul_a = signed'({1'b0, det_src[63:32]});
                2'd2:    mul_a = signed'({1'b0, det_src[95:64]});
                default: mul_a = 33'(signed'(det_src[127:96]));
            endcase
            mul_b = 33'(signed'(r_mat[{2'b00, r_cnt[3:2]}]));
        end
    end

    t_wide prod_ext, acc_next, det_next;
    always_comb begin
        prod_ext = WIDE_W'(mul_p);
        acc_next = (r_ph == 2'd1) ? r_acc + prod_ext : r_acc + (prod_ext << 32);
        det_next = r_det + (prod_ext << {r_cnt[1:0], 5'd0});
    end

    // Divider interface
    t_wide   div_num, div_den, cur;
    logic    div_done;
    logic [31:0] div_q;
    assign cur     = r_adj[r_cnt];
    assign div_num = (cur[WIDE_W-1] ? -cur : cur) << 32;
    assign div_den = r_det[WIDE_W-1] ? -r_det : r_det;

    mi4_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_state == S_DIVGO),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    logic [31:0] lim, qs;
    always_comb begin
        lim = r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        qs  = (div_q > lim) ? lim : div_q;
    end

    assign busy = (r_state != S_LOAD);

    always_ff @(posedge i_clk) begin
        if (start && !busy) r_mat[r_cnt] <= i_elem_value;
        if (r_state == S_COF && r_ph == 2'd2 && r_term == 3'd5) r_adj[r_idx] <= acc_next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            o_out_valid <= 1'b0;
            unique case (r_state)
                S_LOAD: begin
                    if (start) begin
                        r_cnt <= r_cnt + 4'd1;
                        if (r_cnt == 4'd15) begin
                            r_state <= S_COF;
                            r_idx <= '0; r_term <= '0; r_ph <= '0; r_acc <= '0;
                        end
                    end
                end
                S_COF: begin
                    // phases: 0 pair product, 1 low half into the sum,
                    // 2 high half into the sum (last term stores the cofactor)
                    case (r_ph)
                        2'd0: begin
                            r_prod <= mul_p[63:0];
                            r_ph   <= 2'd1;
                        end
                        2'd1: begin
                            r_acc <= acc_next;
                            r_ph  <= 2'd2;
                        end
                        2'd2: begin
                            r_ph <= 2'd0;
                            if (r_term == 3'd5) begin
                                r_acc  <= '0;
                                r_term <= '0;
                                r_idx  <= r_idx + 4'd1;
                                if (r_idx == 4'd15) begin
                                    r_state <= S_DET;
                                    r_cnt   <= '0;
                                    r_det   <= '0;
                                end
                            end else begin
                                r_acc  <= acc_next;
                                r_term <= r_term + 3'd1;
                            end
                        end
                        default: r_ph <= 2'd0;
                    endcase
                end
                S_DET: begin
                    // r_cnt: row element in [3:2], cofactor slice in [1:0]
                    r_det <= det_next;
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) r_state <= S_DIVGO;
                end
                S_DIVGO: begin
                    r_sing  <= (r_det == '0);
                    r_neg   <= cur[WIDE_W-1] ^ r_det[WIDE_W-1];
                    r_state <= S_DIVW;
                end
                S_DIVW: begin
                    if (div_done || r_sing) begin
                        o_out_valid <= 1'b1;
                        o_out_index <= r_cnt;
                        o_out_value <= r_sing ? 32'd0 : (r_neg ? -qs : qs);
                        o_singular  <= r_sing;
                        o_last      <= (r_cnt == 4'd15);
                        r_cnt       <= r_cnt + 4'd1;
                        r_state     <= (r_cnt == 4'd15) ? S_LOAD : S_DIVGO;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- design/mi4_check.sv -----
// Port-level checker for the matrix inverse, bound to the top level.
`default_nettype none
module mi4_check (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_out_valid,
    input wire logic [3:0]  o_out_index,
    input wire logic [31:0] o_out_value,
    input wire logic        o_singular,
    input wire logic        o_last
);
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == (o_out_index == 4'd15)))
        else $error("last flag mismatch");
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_singular) |-> (o_out_value == 32'd0))
        else $error("singular result nonzero");
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $past(busy))
        else $error("result while idle");
    a_end_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> !busy)
        else $error("still busy after last");
endmodule

bind matrix_inverse_4x4 mi4_check u_mi4_check (.*);
`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for matrix_inverse_4x4: streamed 4x4 inverse checked against an exact predictor.
`default_nettype none
module tb;
    import mi4_pkg::*;

    // Wide enough for cofactor * 2^32 and for the determinant without loss.
    typedef logic signed [255:0] t_big;

    typedef struct {
        logic [3:0]  index;
        logic [31:0] value;
        logic        singular;
        logic        last;
    } t_inv_elem;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_elem_value;
    logic        o_out_valid;
    logic [3:0]  o_out_index;
    logic [31:0] o_out_value;
    logic        o_singular;
    logic        o_last;

    matrix_inverse_4x4 dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_elem_value (i_elem_value),
        .o_out_valid  (o_out_valid),
        .o_out_index  (o_out_index),
        .o_out_value  (o_out_value),
        .o_singular   (o_singular),
        .o_last       (o_last)
    );

    // Predictor state: loaded elements and the position within the run.
    t_elem     loaded_mat [ELEMS];
    int        load_pos;
    t_inv_elem pending_inv [$];
    int        mismatch_cnt;
    int        burst_left;
    longint    cycle_cnt;

    localparam longint CYCLE_LIMIT = 2_000_000;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Timeout guard: 23 runs here; the limit lies far above what they take.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Signed cofactor of element (row, col), exact.
    function automatic t_big cofactor_of(input int row, input int col);
        int   rs [3];
        int   cs [3];
        int   n;
        int   k;
        t_big x [3][3];
        n = 0;
        k = 0;
        for (int i = 0; i < 4; i++) begin
            if (i != row) begin
                rs[n] = i;
                n++;
            end
            if (i != col) begin
                cs[k] = i;
                k++;
            end
        end
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                x[a][b] = t_big'(loaded_mat[rs[a]*4 + cs[b]]);
        cofactor_of = x[0][0]*(x[1][1]*x[2][2] - x[1][2]*x[2][1])
                    - x[0][1]*(x[1][0]*x[2][2] - x[1][2]*x[2][0])
                    + x[0][2]*(x[1][0]*x[2][1] - x[1][1]*x[2][0]);
        if (((row + col) & 1) != 0)
            cofactor_of = -cofactor_of;
    endfunction

    // trunc(cof * 2^32 / det), saturated to Q16.16; det nonzero.
    function automatic logic [31:0] quotient_q16(input t_big cof, input t_big det);
        logic       neg;
        logic [255:0] num_mag;
        logic [255:0] det_mag;
        logic [255:0] q;
        logic [255:0] limit;
        t_big       num;
        num     = cof <<< 32;
        neg     = (cof < 0) != (det < 0);
        num_mag = (num < 0) ? -num : num;
        det_mag = (det < 0) ? -det : det;
        q       = num_mag / det_mag;
        limit   = neg ? 256'h8000_0000 : 256'h7FFF_FFFF;
        if (q > limit)
            q = limit;
        quotient_q16 = neg ? -q[31:0] : q[31:0];
    endfunction

    // Record one accepted element; on the sixteenth, queue the inverse.
    task automatic predict_inverse(input logic [31:0] v);
        t_big      adj [ELEMS];
        t_big      det;
        t_inv_elem e;
        loaded_mat[load_pos] = v;
        if (load_pos < ELEMS - 1) begin
            load_pos++;
            return;
        end
        load_pos = 0;
        // adjugate entry (r, c) is the cofactor of element (c, r)
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                adj[r*4 + c] = cofactor_of(c, r);
        det = '0;
        for (int j = 0; j < 4; j++)
            det += adj[j*4] * t_big'(loaded_mat[j]);
        for (int j = 0; j < ELEMS; j++) begin
            e.index    = j[3:0];
            e.singular = (det == 0);
            e.value    = (det == 0) ? 32'd0 : quotient_q16(adj[j], det);
            e.last     = (j == ELEMS - 1);
            pending_inv.push_back(e);
        end
    endtask

    // One request. start stays high into the next request of a burst; a gap
    // between bursts lowers it first.
    task automatic send_elem(input logic [31:0] v);
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        burst_left--;
        start        <= 1'b1;
        i_elem_value <= v;
        do @(posedge i_clk); while (busy);
        predict_inverse(v);
    endtask

    task automatic send_matrix(input logic [31:0] m [ELEMS]);
        for (int i = 0; i < ELEMS; i++)
            send_elem(m[i]);
    endtask

    // Checker: every strobed result against the oldest expectation.
    always @(posedge i_clk) begin
        t_inv_elem e;
        if (i_rst_n && o_out_valid) begin
            if (pending_inv.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result: idx=%0d val=%h sing=%b last=%b",
                             o_out_index, o_out_value, o_singular, o_last);
            end else begin
                e = pending_inv.pop_front();
                if (o_out_index !== e.index || o_out_value !== e.value ||
                    o_singular !== e.singular || o_last !== e.last) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display({"result mismatch: exp idx=%0d val=%h sing=%b last=%b,",
                                  " got idx=%0d val=%h sing=%b last=%b"},
                                 e.index, e.value, e.singular, e.last,
                                 o_out_index, o_out_value, o_singular, o_last);
                end
            end
        end
    end

    // Diagonal with 1.0, largest, most negative and smallest step: covers the
    // field extremes and saturation of the inverse.
    task automatic test_extremes();
        logic [31:0] m [ELEMS];
        foreach (m[i]) m[i] = 32'd0;
        m[0]  = 32'h0001_0000;
        m[5]  = 32'h7FFF_FFFF;
        m[10] = 32'h8000_0000;
        m[15] = 32'h0000_0001;
        send_matrix(m);
    endtask

    // Random content with a repeated row, or a zero row: determinant zero.
    task automatic test_singular();
        logic [31:0] m [ELEMS];
        int          src;
        int          dst;
        logic        zero_row;
        foreach (m[i]) m[i] = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h3_FFFF);
        src      = $urandom_range(0, 3);
        dst      = (src + $urandom_range(1, 3)) % 4;
        zero_row = $urandom_range(0, 1);
        for (int c = 0; c < 4; c++)
            m[dst*4 + c] = zero_row ? 32'd0 : m[src*4 + c];
        send_matrix(m);
    endtask

    // Mostly well-conditioned small values; some full range, some tiny
    // (overflowing inverse), some singular.
    task automatic test_random(input int runs);
        logic [31:0] m [ELEMS];
        int          kind;
        for (int n = 0; n < runs; n++) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                test_singular();
            end else begin
                foreach (m[i]) begin
                    case (kind)
                        1, 2:    m[i] = $urandom;
                        3:       m[i] = $urandom_range(0, 64) - 32;
                        default: m[i] = $urandom_range(0, 32'h8_0000) - 32'h4_0000;
                    endcase
                end
                if (kind >= 7)
                    for (int d = 0; d < 4; d++)
                        m[d*5] = m[d*5] + 32'h0008_0000;  // diagonal boost
                send_matrix(m);
            end
        end
    endtask

    initial begin
        longint waited;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_elem_value = 32'd0;
        cycle_cnt    = 0;
        load_pos     = 0;
        mismatch_cnt = 0;
        burst_left   = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_singular();
        test_random(21);

        start <= 1'b0;
        waited = 0;
        while (pending_inv.size() != 0) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
